// ===== hdl/tfn_pkg.sv =====
// tfn_pkg: shared constants, widths and types of the triangle face normal block
// depends on nothing; imported by every other file of the block but the interfaces and checker
`default_nettype none

package tfn_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int COORD_BITS   = 12;

  localparam int ADDR_W  = $clog2(VERTEX_DEPTH);
  localparam int INDEX_W = 10;
  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int CROSS_W = 2 * EDGE_W + 1;
  // magnitude register, wide enough for the raw cross product and the scaled value
  localparam int NW      = (2 * EDGE_W > 31) ? 2 * EDGE_W : 31;
  localparam int MW      = (EDGE_W > 31) ? EDGE_W : 31;
  localparam int PW      = 2 * MW;
  localparam int SUM_W   = 62;
  localparam int LEN_W   = 31;
  localparam int QW      = 16;
  localparam int CNT_W   = 5;
  localparam int FRAC_BITS = 14;
  localparam int SCALE_LO  = 29;
  localparam int SCALE_HI  = 30;

  localparam logic [QW-1:0]    UNIT_ONE   = QW'(16384);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(SUM_W / 2 - 1);
  localparam logic [CNT_W-1:0] DIV_LOAD   = CNT_W'(QW);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FACE  = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    vertex_t           data;
  } vs_wr_t;

endpackage

`default_nettype wire

// ===== hdl/tfn_if.sv =====
// tfn_req_if and tfn_rsp_if: valid/ready channels carrying face requests and normals
// depends on nothing
`default_nettype none

interface tfn_req_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [9:0]         index_a;
  logic [9:0]         index_b;
  logic [9:0]         index_c;
  logic signed [11:0] coord_x;
  logic signed [11:0] coord_y;
  logic signed [11:0] coord_z;
  modport source (output valid, operation, index_a, index_b, index_c,
                  coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, operation, index_a, index_b, index_c,
                  coord_x, coord_y, coord_z, output ready);
endinterface

interface tfn_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [15:0]        face_number;
  logic               degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, face_number,
                  degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, face_number,
                  degenerate, output ready);
endinterface

`default_nettype wire

// ===== hdl/tfn_vstore.sv =====
// tfn_vstore: vertex store, one write and one registered read per cycle
// depends on tfn_pkg
`default_nettype none

module tfn_vstore (
  input  wire logic                  clk,
  input  wire tfn_pkg::vs_wr_t       wr,
  input  wire logic [tfn_pkg::ADDR_W-1:0] raddr,
  output      tfn_pkg::vertex_t      rdata
);
  import tfn_pkg::*;

  vertex_t mem [VERTEX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tfn_mul.sv =====
// tfn_mul: shared signed multiplier with registered product
// depends on tfn_pkg
`default_nettype none

module tfn_mul (
  input  wire logic                        clk,
  input  wire logic signed [tfn_pkg::MW-1:0] a,
  input  wire logic signed [tfn_pkg::MW-1:0] b,
  output      logic signed [tfn_pkg::PW-1:0] p
);
  import tfn_pkg::*;

  always_ff @(posedge clk) begin
    p <= PW'(a) * PW'(b);
  end

endmodule

`default_nettype wire

// ===== hdl/tfn_csub.sv =====
// tfn_csub: shared compare and subtract step for square root and division
// depends on tfn_pkg
`default_nettype none

module tfn_csub (
  input  wire logic [tfn_pkg::SUM_W-1:0] a,
  input  wire logic [tfn_pkg::SUM_W-1:0] b,
  output      logic                      ge,
  output      logic [tfn_pkg::SUM_W-1:0] diff
);
  import tfn_pkg::*;

  logic [SUM_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[SUM_W];
  assign diff = wide[SUM_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/triangle_face_normal.sv =====
// triangle_face_normal: unit face normal of a triangle from a vertex store
// a vertex write is taken while idle and gives no result; a face request fetches the
// corners, forms the cross product, scales it, then runs the 31-step square root and
// three divisions on one compare-subtract unit; a degenerate face skips to the result
// one face is in flight at a time; a finished normal waits in an output register
// rst is synchronous active high: clears sequencer, face counter and output valid
`default_nettype none

module triangle_face_normal (
  input wire logic clk,
  input wire logic rst,
  tfn_req_if.sink   req,
  tfn_rsp_if.source rsp
);
  import tfn_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_FETCH  = 10'b00_0000_0010,
    S_EDGE   = 10'b00_0000_0100,
    S_CROSS  = 10'b00_0000_1000,
    S_CHECK  = 10'b00_0001_0000,
    S_NORM   = 10'b00_0010_0000,
    S_SQUARE = 10'b00_0100_0000,
    S_SQRT   = 10'b00_1000_0000,
    S_DIV    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       comp;

  // latched face request
  logic [INDEX_W-1:0] idx_a, idx_b, idx_c;
  logic [2:0]         rng;
  logic [15:0]        face_cnt, face_num;

  vertex_t va, vb, vc;
  logic signed [EDGE_W-1:0]  e1 [3];
  logic signed [EDGE_W-1:0]  e2 [3];
  logic signed [CROSS_W-1:0] cr [3];
  logic [2:0]                sgn;
  logic [NW-1:0]             mg [3];
  logic [SUM_W-1:0]          sum, rem, res;
  logic [LEN_W-1:0]          len;
  logic [QW-1:0]             q;
  logic signed [15:0]        nrm [3];
  logic                      degen;

  // output register
  logic               o_valid;
  logic signed [15:0] o_nx, o_ny, o_nz;
  logic [15:0]        o_num;
  logic               o_degen;

  // shared units
  vs_wr_t                  vs_wr;
  logic [ADDR_W-1:0]       vs_raddr;
  vertex_t                 vs_rdata;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [SUM_W-1:0]        cs_a, cs_b, cs_diff;
  logic                    cs_ge;

  logic req_acc, out_free;
  logic [NW-1:0]    orv;
  logic             too_big, too_small;
  logic [SUM_W-1:0] sq_bit, sum_next, res_next;
  logic [QW-1:0]    q_fin, q_sat;
  logic [INDEX_W-1:0] rd_idx;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign out_free  = !o_valid || rsp.ready;

  assign rsp.valid       = o_valid;
  assign rsp.normal_x    = o_nx;
  assign rsp.normal_y    = o_ny;
  assign rsp.normal_z    = o_nz;
  assign rsp.face_number = o_num;
  assign rsp.degenerate  = o_degen;

  // vertex writes go straight to the store; slots beyond the depth are dropped
  always_comb begin
    vs_wr.en     = req_acc && (req.operation == OP_WRITE)
                   && (32'(req.index_a) < VERTEX_DEPTH);
    vs_wr.addr   = ADDR_W'(req.index_a);
    vs_wr.data.x = COORD_BITS'($unsigned(req.coord_x));
    vs_wr.data.y = COORD_BITS'($unsigned(req.coord_y));
    vs_wr.data.z = COORD_BITS'($unsigned(req.coord_z));
  end

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    rd_idx = idx_a;
      2'd1:    rd_idx = idx_b;
      default: rd_idx = idx_c;
    endcase
  end
  assign vs_raddr = ADDR_W'(rd_idx);

  tfn_vstore u_vstore (
    .clk   (clk),
    .wr    (vs_wr),
    .raddr (vs_raddr),
    .rdata (vs_rdata)
  );

  // multiplier operands: six cross terms, then three squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      unique case (cnt[2:0])
        3'd0:    begin mul_a = MW'(e1[1]); mul_b = MW'(e2[2]); end
        3'd1:    begin mul_a = MW'(e1[2]); mul_b = MW'(e2[1]); end
        3'd2:    begin mul_a = MW'(e1[2]); mul_b = MW'(e2[0]); end
        3'd3:    begin mul_a = MW'(e1[0]); mul_b = MW'(e2[2]); end
        3'd4:    begin mul_a = MW'(e1[0]); mul_b = MW'(e2[1]); end
        3'd5:    begin mul_a = MW'(e1[1]); mul_b = MW'(e2[0]); end
        default: begin mul_a = '0;         mul_b = '0;         end
      endcase
    end else if (state == S_SQUARE) begin
      unique case (cnt[1:0])
        2'd0:    mul_a = MW'($signed({1'b0, mg[0][SCALE_HI-1:0]}));
        2'd1:    mul_a = MW'($signed({1'b0, mg[1][SCALE_HI-1:0]}));
        2'd2:    mul_a = MW'($signed({1'b0, mg[2][SCALE_HI-1:0]}));
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end
  end

  tfn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // compare-subtract operands: square root trial or shifted divisor
  assign sq_bit = SUM_W'(1) << {cnt, 1'b0};
  always_comb begin
    cs_a = rem;
    if (state == S_SQRT) begin
      cs_b = res | sq_bit;
    end else begin
      cs_b = SUM_W'(len) << cnt;
    end
  end

  tfn_csub u_csub (
    .a    (cs_a),
    .b    (cs_b),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  assign orv       = mg[0] | mg[1] | mg[2];
  assign too_big   = |orv[NW-1:SCALE_HI];
  assign too_small = ~(|orv[NW-1:SCALE_LO]);
  assign sum_next  = ((cnt == CNT_W'(1)) ? '0 : sum) + SUM_W'(mul_p);
  assign res_next  = cs_ge ? ((res >> 1) | sq_bit) : (res >> 1);
  assign q_fin     = q | QW'(cs_ge);
  assign q_sat     = (q_fin > UNIT_ONE) ? UNIT_ONE : q_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      comp     <= '0;
      face_cnt <= '0;
      o_valid  <= 1'b0;
    end else begin
      // a taken result clears, unless a new normal is loaded in the same cycle
      if (o_valid && rsp.ready && (state != S_DONE)) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc && (req.operation == OP_FACE)) begin
            idx_a    <= req.index_a;
            idx_b    <= req.index_b;
            idx_c    <= req.index_c;
            rng[0]   <= 32'(req.index_a) < VERTEX_DEPTH;
            rng[1]   <= 32'(req.index_b) < VERTEX_DEPTH;
            rng[2]   <= 32'(req.index_c) < VERTEX_DEPTH;
            face_num <= face_cnt;
            face_cnt <= face_cnt + 16'd1;
            cnt      <= '0;
            state    <= S_FETCH;
          end
        end
        S_FETCH: begin
          // data trails its address by the read register; out-of-range corners read zero
          unique case (cnt[1:0])
            2'd1:    va <= rng[0] ? vs_rdata : '0;
            2'd2:    vb <= rng[1] ? vs_rdata : '0;
            2'd3:    vc <= rng[2] ? vs_rdata : '0;
            default: ;
          endcase
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(3)) begin
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          e1[0] <= EDGE_W'(vb.x) - EDGE_W'(va.x);
          e1[1] <= EDGE_W'(vb.y) - EDGE_W'(va.y);
          e1[2] <= EDGE_W'(vb.z) - EDGE_W'(va.z);
          e2[0] <= EDGE_W'(vc.x) - EDGE_W'(va.x);
          e2[1] <= EDGE_W'(vc.y) - EDGE_W'(va.y);
          e2[2] <= EDGE_W'(vc.z) - EDGE_W'(va.z);
          cnt   <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          // product of term n lands at count n+1: first term loads, second subtracts
          unique case (cnt[2:0])
            3'd1:    cr[0] <= CROSS_W'(mul_p);
            3'd2:    cr[0] <= cr[0] - CROSS_W'(mul_p);
            3'd3:    cr[1] <= CROSS_W'(mul_p);
            3'd4:    cr[1] <= cr[1] - CROSS_W'(mul_p);
            3'd5:    cr[2] <= CROSS_W'(mul_p);
            3'd6:    cr[2] <= cr[2] - CROSS_W'(mul_p);
            default: ;
          endcase
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(6)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          for (int k = 0; k < 3; k++) begin
            sgn[k] <= cr[k][CROSS_W-1];
            mg[k]  <= NW'(cr[k][CROSS_W-1] ? -cr[k] : cr[k]);
          end
          if (cr[0] == '0 && cr[1] == '0 && cr[2] == '0) begin
            nrm[0] <= '0;
            nrm[1] <= '0;
            nrm[2] <= '0;
            degen  <= 1'b1;
            state  <= S_DONE;
          end else begin
            degen  <= 1'b0;
            state  <= S_NORM;
          end
        end
        S_NORM: begin
          // common power-of-two scaling until the largest magnitude sits in [2^29, 2^30)
          priority if (too_big) begin
            for (int k = 0; k < 3; k++) mg[k] <= mg[k] >> 1;
          end else if (too_small) begin
            for (int k = 0; k < 3; k++) mg[k] <= mg[k] << 1;
          end else begin
            cnt   <= '0;
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (cnt != '0) begin
            sum <= sum_next;
          end
          if (cnt == CNT_W'(3)) begin
            rem   <= sum_next;
            res   <= '0;
            cnt   <= SQRT_STEPS;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_SQRT: begin
          if (cs_ge) begin
            rem <= cs_diff;
          end
          res <= res_next;
          if (cnt == '0) begin
            len   <= LEN_W'(res_next);
            comp  <= '0;
            cnt   <= DIV_LOAD;
            state <= S_DIV;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_DIV: begin
          if (cnt == DIV_LOAD) begin
            // numerator |c| * 2^14 plus half the length, for rounding half away from zero
            rem <= (SUM_W'(mg[comp][SCALE_HI-1:0]) << FRAC_BITS) + SUM_W'(len >> 1);
            q   <= '0;
            cnt <= cnt - CNT_W'(1);
          end else begin
            if (cs_ge) begin
              rem    <= cs_diff;
              q[cnt[3:0]] <= 1'b1;
            end
            if (cnt == '0) begin
              nrm[comp] <= sgn[comp] ? -$signed(q_sat) : $signed(q_sat);
              cnt       <= DIV_LOAD;
              comp      <= comp + 2'd1;
              if (comp == 2'd2) begin
                state <= S_DONE;
              end
            end else begin
              cnt <= cnt - CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_nx    <= nrm[0];
            o_ny    <= nrm[1];
            o_nz    <= nrm[2];
            o_num   <= face_num;
            o_degen <= degen;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tfn_checker.sv =====
// tfn_checker: port-level assertions on triangle_face_normal, bound to the top level
// depends on triangle_face_normal and its channel interfaces
`default_nettype none

module tfn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] normal_x,
  input wire logic [15:0] normal_y,
  input wire logic [15:0] normal_z,
  input wire logic [15:0] face_number,
  input wire logic        degenerate
);

  // nothing is shown straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a result never follows a request in the very next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
    else $error("result appeared one cycle after a request");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(face_number)
      && $stable(normal_x) && $stable(normal_y) && $stable(normal_z))
    else $error("stalled result changed");

  // a degenerate face carries a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && degenerate) |-> (normal_x == 16'd0 && normal_y == 16'd0
      && normal_z == 16'd0))
    else $error("degenerate face with non-zero normal");

  // components stay within plus or minus one in Q1.14
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($signed(normal_x) <= 16384 && $signed(normal_x) >= -16384
      && $signed(normal_y) <= 16384 && $signed(normal_y) >= -16384
      && $signed(normal_z) <= 16384 && $signed(normal_z) >= -16384))
    else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .normal_x    (rsp.normal_x),
  .normal_y    (rsp.normal_y),
  .normal_z    (rsp.normal_z),
  .face_number (rsp.face_number),
  .degenerate  (rsp.degenerate)
);

`default_nettype wire

// ===== dv/triangle_face_normal_test.sv =====
// triangle_face_normal_test: self-checking bench for the triangle face normal block
// depends on tfn_pkg, tfn_req_if/tfn_rsp_if and triangle_face_normal
`default_nettype none

module triangle_face_normal_test;
  import tfn_pkg::*;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]        face;
    logic               degen;
  } normal_t;

  // expected normals in request order, plus a shadow of the vertex store
  class normal_board;
    normal_t             pending[$];
    logic signed [11:0]  shadow_x[VERTEX_DEPTH];
    logic signed [11:0]  shadow_y[VERTEX_DEPTH];
    logic signed [11:0]  shadow_z[VERTEX_DEPTH];
    logic [15:0]         face_count;
    int                  errors;
    int                  checked;
    int                  degen_seen;

    function void clear();
      pending.delete();
      face_count = 0;
    endfunction

    function longint corner(int idx, int axis);
      if (idx >= VERTEX_DEPTH) return 0;
      case (axis)
        0: return shadow_x[idx];
        1: return shadow_y[idx];
        default: return shadow_z[idx];
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // notes one accepted request; a face request predicts its normal
    function void note_request(logic op, int ia, int ib, int ic,
                               logic signed [11:0] x, logic signed [11:0] y,
                               logic signed [11:0] z);
      longint e1[3], e2[3], cr[3];
      longint unsigned mg[3], mx, len, q;
      normal_t n;
      if (op == OP_WRITE) begin
        if (ia < VERTEX_DEPTH) begin
          shadow_x[ia] = x;
          shadow_y[ia] = y;
          shadow_z[ia] = z;
        end
        return;
      end
      for (int k = 0; k < 3; k++) begin
        e1[k] = corner(ib, k) - corner(ia, k);
        e2[k] = corner(ic, k) - corner(ia, k);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      n.face = face_count;
      face_count++;
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        mg[k] = cr[k] < 0 ? -cr[k] : cr[k];
        if (mg[k] > mx) mx = mg[k];
      end
      n.nx = 0;
      n.ny = 0;
      n.nz = 0;
      n.degen = (mx == 0);
      if (mx != 0) begin
        // bring the largest component into [2^29, 2^30)
        while (mx < (64'd1 << SCALE_LO)) begin
          mx <<= 1;
          for (int k = 0; k < 3; k++) mg[k] <<= 1;
        end
        while (mx >= (64'd1 << SCALE_HI)) begin
          mx >>= 1;
          for (int k = 0; k < 3; k++) mg[k] >>= 1;
        end
        len = root(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
        if (len == 0) len = 1;
        for (int k = 0; k < 3; k++) begin
          q = (mg[k] * 16384 + (len >> 1)) / len;
          if (q > 16384) q = 16384;
          if (cr[k] < 0) q = -q;
          case (k)
            0: n.nx = q[15:0];
            1: n.ny = q[15:0];
            default: n.nz = q[15:0];
          endcase
        end
      end
      pending = {pending, n};
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_normal(normal_t got);
      normal_t w;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: normal for face %0d with none expected", $time, got.face);
        return;
      end
      w = pending.pop_front();
      if (w.degen) degen_seen++;
      if (got.nx !== w.nx) report("normal_x", w.nx, got.nx);
      if (got.ny !== w.ny) report("normal_y", w.ny, got.ny);
      if (got.nz !== w.nz) report("normal_z", w.nz, got.nz);
      if (got.face !== w.face) report("face_number", w.face, got.face);
      if (got.degen !== w.degen) report("degenerate", w.degen, got.degen);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  tfn_req_if req ();
  tfn_rsp_if rsp ();

  triangle_face_normal dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  normal_board board = new();

  bit     calm;          // stretch with no idling on either side
  bit     hold_off;      // long receiver stall
  int     requests_sent;
  longint cycle = 0;
  int     written[$];    // slots written so far

  localparam longint CYCLE_LIMIT = 2_000_000;

  // timeout guard
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("triangle_face_normal_test: errors");
      $finish;
    end
  end

  // monitor: note requests and check normals at the same edge they are accepted
  always @(posedge clk) begin
    normal_t got;
    if (!rst && req.valid && req.ready)
      board.note_request(req.operation, req.index_a, req.index_b, req.index_c,
                         req.coord_x, req.coord_y, req.coord_z);
    if (!rst && rsp.valid && rsp.ready) begin
      got.nx = rsp.normal_x;
      got.ny = rsp.normal_y;
      got.nz = rsp.normal_z;
      got.face = rsp.face_number;
      got.degen = rsp.degenerate;
      board.check_normal(got);
    end
  end

  // receiver: random stalls about 11 in 100, none in calm stretches
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        rsp.ready <= 1'b0;
        // hold off for a long, cycle-counted stretch
        for (stall = 0; stall < 2000; stall++) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
        @(posedge clk);
      end
    end
  end

  // present one request and wait for it to be taken; valid stays up for the next one
  task automatic send_request(logic op, int ia, int ib, int ic,
                              int x, int y, int z);
    while (!calm && $urandom_range(99) < 11) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.index_a   <= ia[9:0];
    req.index_b   <= ib[9:0];
    req.index_c   <= ic[9:0];
    req.coord_x   <= x[11:0];
    req.coord_y   <= y[11:0];
    req.coord_z   <= z[11:0];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    requests_sent++;
    if (op == OP_WRITE && ia < VERTEX_DEPTH) written = {written, ia};
  endtask

  task automatic put_vertex(int slot, int x, int y, int z);
    send_request(OP_WRITE, slot, $urandom, $urandom, x, y, z);
  endtask

  task automatic ask_face(int ia, int ib, int ic);
    send_request(OP_FACE, ia, ib, ic, $urandom, $urandom, $urandom);
  endtask

  function automatic int any_written();
    return written[$urandom_range(written.size() - 1)];
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(5))
      0: return -2048;
      1: return 2047;
      2: return $urandom_range(8) - 4;
      default: return $urandom_range(4095) - 2048;
    endcase
  endfunction

  // stop sending until every expected normal has arrived
  task automatic drain();
    req.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int mesh_base;
    req.valid = 1'b0;
    req.operation = OP_WRITE;
    req.index_a = '0;
    req.index_b = '0;
    req.index_c = '0;
    req.coord_x = '0;
    req.coord_y = '0;
    req.coord_z = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    board.errors = 0;
    board.checked = 0;
    board.degen_seen = 0;
    board.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme corners, axis-aligned faces, degenerate and odd slots
    put_vertex(0, 0, 0, 0);
    put_vertex(1, 2047, 0, 0);
    put_vertex(2, 0, 2047, 0);
    put_vertex(3, -2048, -2048, -2048);
    put_vertex(1023, 2047, 2047, 2047);
    put_vertex(4, -2048, 2047, -2048);
    put_vertex(5, 1, 0, 0);
    put_vertex(6, 0, 1, 0);
    ask_face(0, 1, 2);          // +z
    ask_face(0, 2, 1);          // -z
    ask_face(0, 5, 6);          // tiny cross product, heavy scale-up
    ask_face(3, 1023, 4);       // extreme coordinates
    ask_face(3, 4, 1023);
    ask_face(1, 1, 2);          // repeated corner gives a degenerate face
    ask_face(0, 5, 1);          // collinear corners
    ask_face(1023, 1023, 1023);
    put_vertex(1500, 99, 99, 99);  // upper index bits fall off the 10-bit field
    ask_face(1023, 1500, 2047);
    ask_face(2047, 1, 2);
    put_vertex(7, -5, 3, 2047);
    ask_face(7, 3, 4);

    // random mesh traffic; a calm stretch in the middle
    for (int n = 0; n < 920; n++) begin
      calm = (n >= 400 && n < 600);
      if (n == 700) begin
        // fill the block up while the receiver holds off
        hold_off = 1'b1;
        req.valid <= 1'b0;
        @(posedge clk);
      end
      if (n == 900) drain();
      case ($urandom_range(9))
        0, 1, 2: put_vertex($urandom_range(1023), rand_coord(), rand_coord(),
                            rand_coord());
        3: begin
          mesh_base = $urandom_range(1020);
          put_vertex(mesh_base, rand_coord(), rand_coord(), rand_coord());
          put_vertex(mesh_base + 1, rand_coord(), rand_coord(), rand_coord());
          put_vertex(mesh_base + 2, rand_coord(), rand_coord(), rand_coord());
          ask_face(mesh_base, mesh_base + 1, mesh_base + 2);
        end
        4: put_vertex($urandom_range(2047, 1024), $urandom, $urandom, $urandom);
        5: begin
          // repeated corner, always degenerate
          mesh_base = any_written();
          ask_face(mesh_base, any_written(), mesh_base);
        end
        default: ask_face(any_written(), any_written(), any_written());
      endcase
    end
    calm = 1'b0;

    drain();
    repeat (200) @(posedge clk);
    $display("%0d requests sent, %0d normals checked, %0d degenerate faces",
             requests_sent, board.checked, board.degen_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("triangle_face_normal_test: clean");
    end else begin
      $display("%0d mismatches, %0d normals outstanding", board.errors,
               board.pending.size());
      $display("triangle_face_normal_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
